FILE: hdl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// shared types, codes and defaults of the ppm frame decoder
// ----------------------------------------------------------------------------
package ppm_pkg;

    // default sizing
    localparam int PPM_CHANNELS  = 16;
    localparam int PPM_TIME_BITS = 16;

    // fixed field widths
    localparam int TICK_W     = 16;
    localparam int PORT_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int PIN_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [PIN_W-1:0]  PIN_SELECT_RST       = 5'd0;
    localparam logic [TICK_W-1:0] SYNC_THRESHOLD_RST   = 16'd3000;
    localparam logic [TICK_W-1:0] INACTIVITY_LIMIT_RST = 16'd25000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_SELECT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY_LIMIT = 2'd2;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port_word;
        logic [TICK_W-1:0] timestamp;
        logic [SLOT_W-1:0] read_slot;
    } in_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] pulse_ticks;
        logic              signal_active;
    } out_item_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_select;
        logic [TICK_W-1:0] sync_threshold;
        logic [TICK_W-1:0] inactivity_limit;
    } cfg_t;

endpackage

FILE: hdl/ppm_stream_if.sv
// ----------------------------------------------------------------------------
// ppm_stream_if
// valid/ready stream channel with a typed payload
// ----------------------------------------------------------------------------
interface ppm_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/ppm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppm_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module ppm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data,
    output ppm_pkg::cfg_t                  cfg
);

    ppm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_select       <= ppm_pkg::PIN_SELECT_RST;
            cfg_reg.sync_threshold   <= ppm_pkg::SYNC_THRESHOLD_RST;
            cfg_reg.inactivity_limit <= ppm_pkg::INACTIVITY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppm_pkg::CFG_PIN_SELECT:
                    cfg_reg.pin_select <= cfg_data[ppm_pkg::PIN_W-1:0];
                ppm_pkg::CFG_SYNC_THRESHOLD:
                    cfg_reg.sync_threshold <= cfg_data[ppm_pkg::TICK_W-1:0];
                ppm_pkg::CFG_INACTIVITY_LIMIT:
                    cfg_reg.inactivity_limit <= cfg_data[ppm_pkg::TICK_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ppm_decode_core.sv
// ----------------------------------------------------------------------------
// ppm_decode_core
// edge timing, slot store and activity flag; one item per step
// ----------------------------------------------------------------------------
module ppm_decode_core #(
    parameter int CHANNELS  = ppm_pkg::PPM_CHANNELS,
    parameter int TIME_BITS = ppm_pkg::PPM_TIME_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ppm_pkg::cfg_t       cfg,
    input  logic                step,
    input  ppm_pkg::in_item_t   item,
    output ppm_pkg::out_item_t  result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = (TIME_BITS > ppm_pkg::TICK_W) ? TIME_BITS : ppm_pkg::TICK_W;
    localparam int RS_W  = ((IDX_W > ppm_pkg::SLOT_W) ? IDX_W : ppm_pkg::SLOT_W) + 1;

    logic                      last_level_reg, last_level_next;
    logic [TIME_BITS-1:0]      last_fall_reg, last_fall_next;
    logic [IDX_W-1:0]          slot_index_reg, slot_index_next;
    logic                      active_reg, active_next;
    logic [ppm_pkg::TICK_W-1:0] slot_store_reg [CHANNELS];

    logic [CMP_W-1:0]          ts_ext;
    logic [TIME_BITS-1:0]      now;
    logic [TIME_BITS-1:0]      gap;
    logic [CMP_W-1:0]          gap_ext;
    logic                      level;
    logic                      frame_start;
    logic                      wr_en;
    logic [RS_W-1:0]           rs_ext;
    logic                      rs_in_range;
    logic [IDX_W-1:0]          rs_idx;

    always_comb
    begin
        ts_ext      = CMP_W'(item.timestamp);
        now         = ts_ext[TIME_BITS-1:0];
        gap         = now - last_fall_reg;      // wraps at the timer width
        gap_ext     = CMP_W'(gap);
        level       = item.port_word[cfg.pin_select];
        frame_start = gap_ext > CMP_W'(cfg.sync_threshold);
        rs_ext      = RS_W'(item.read_slot);
        rs_in_range = rs_ext < RS_W'(CHANNELS);
        rs_idx      = rs_ext[IDX_W-1:0];

        last_level_next    = last_level_reg;
        last_fall_next     = last_fall_reg;
        slot_index_next    = slot_index_reg;
        active_next        = active_reg;
        wr_en              = 1'b0;
        result.pulse_ticks = '0;

        unique case (item.func)
            ppm_pkg::FUNC_SAMPLE:
            begin
                if (level != last_level_reg)
                begin
                    last_level_next = level;
                    if (!level)
                    begin
                        if (frame_start)
                        begin
                            slot_index_next = '0;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (slot_index_reg == IDX_W'(CHANNELS - 1))
                                slot_index_next = '0;
                            else
                                slot_index_next = slot_index_reg + 1'b1;
                        end
                        active_next    = 1'b1;
                        last_fall_next = now;
                    end
                end
            end
            ppm_pkg::FUNC_TIMEOUT:
            begin
                if (active_reg && (gap_ext > CMP_W'(cfg.inactivity_limit)))
                    active_next = 1'b0;
            end
            ppm_pkg::FUNC_READ:
            begin
                if (rs_in_range)
                    result.pulse_ticks = slot_store_reg[rs_idx];
            end
            default: ;  // unused code, no effect
        endcase

        result.signal_active = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            last_fall_reg  <= '0;
            slot_index_reg <= '0;
            active_reg     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                slot_store_reg[i] <= '0;
        end
        else if (step)
        begin
            last_level_reg <= last_level_next;
            last_fall_reg  <= last_fall_next;
            slot_index_reg <= slot_index_next;
            active_reg     <= active_next;
            if (wr_en)
                slot_store_reg[slot_index_reg] <= gap_ext[ppm_pkg::TICK_W-1:0];
        end
    end

endmodule

FILE: hdl/ppm_frame_decoder.sv
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// rc ppm pulse train decoder with slot readback and activity timeout
// ----------------------------------------------------------------------------
// path: an input transfer passes the input register, then the result register
// throughput: 1 item per cycle while the output is not stalled, set by the single
//   decode pass whose state updates in the same cycle it produces the result
// reset: rst_n clears config to defaults, state, slot store and both stages
// ----------------------------------------------------------------------------
module ppm_frame_decoder #(
    parameter int CHANNELS  = ppm_pkg::PPM_CHANNELS,
    parameter int TIME_BITS = ppm_pkg::PPM_TIME_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data,
    ppm_stream_if.sink                     in_ch,
    ppm_stream_if.source                   out_ch
);

    // config registers
    ppm_pkg::cfg_t      cfg;

    // input stage
    logic               s1_valid_reg;
    ppm_pkg::in_item_t  s1_item_reg;

    // result stage
    logic               out_valid_reg;
    ppm_pkg::out_item_t out_item_reg;

    ppm_pkg::out_item_t core_result;
    logic               out_free;
    logic               s1_advance;
    logic               in_xfer;

    ppm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the core commits its state only when the item moves into the result stage
    ppm_decode_core #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (s1_advance),
        .item   (s1_item_reg),
        .result (core_result)
    );

    // result register empty or being drained this cycle
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign s1_advance = s1_valid_reg && out_free;
    // input stage can take a new transfer whenever its item moves on
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= in_ch.data;
        if (s1_advance)
            out_item_reg <= core_result;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

    // an input transfer always lands in the input stage
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("input transfer did not fill the input stage");

    // a stalled result must block the decode step
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !s1_advance)
        else $error("decode step while result stalled");

    // every decode step shows up as a valid result next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_ch.valid)
        else $error("decode step lost its result");

endmodule
